[rtl/e2c_pkg.sv]
// shared types, constants and tables for the epoch seconds to calendar block
// no dependencies; imported by every module of the block
package e2c_pkg;

    // depth of the queue between the front and the back end
    localparam int FIFO_DEPTH = 2;

    // division by a constant as q = (x * RECIP) >> SHIFT
    // 60 and 24 are exact for any 32-bit dividend, 7 for dividends below 2^32 / 3
    localparam logic [31:0] RECIP_60       = 32'h8888_8889;
    localparam int          RECIP_60_SHIFT = 37;
    localparam logic [31:0] RECIP_24       = 32'hAAAA_AAAB;
    localparam int          RECIP_24_SHIFT = 36;
    localparam logic [31:0] RECIP_7        = 32'h2492_4925;
    localparam int          RECIP_7_SHIFT  = 32;

    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_PER_DAY  = 24;
    localparam int DAYS_PER_WEEK = 7;

    localparam logic [15:0] DAYS_1970_TO_2099 = 16'd47482;
    localparam logic [11:0] BASE_YEAR         = 12'd1970;
    localparam logic [8:0]  DAYS_YEAR         = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR    = 9'd366;
    // 1970 + n is a leap year when n mod 4 is 2
    localparam logic [1:0]  LEAP_PHASE        = 2'd2;

    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    // configuration register indexes
    localparam logic [1:0] REG_ZONE_OFFSET  = 2'd0;
    localparam logic [1:0] REG_WEEKDAY_BASE = 2'd1;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SEC,
        F_MIN,
        F_ZONE,
        F_HOUR,
        F_CHK,
        F_WDAY,
        F_PUSH
    } e2c_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_YEAR,
        B_MONTH,
        B_OUT
    } e2c_back_state_t;

    // classified item handed from front to back
    typedef struct packed {
        logic        oor;
        logic [15:0] days;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } e2c_item_t;

    typedef struct packed {
        logic        oor;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } e2c_result_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/e2c_front.sv]
// front end: accepts epoch seconds, splits off second, minute and hour by
// reciprocal multiplication, applies the zone offset; uses e2c_pkg
module e2c_front
    import e2c_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       in_seconds,
    input  logic [4:0]        zone_offset_hours,
    output logic              out_valid,
    input  logic              out_ready,
    output e2c_item_t         out_item
);

    e2c_front_state_t state_reg, state_next;
    logic [31:0]      dvd_reg, dvd_next;
    logic [31:0]      quo_reg, quo_next;
    logic             phase_reg, phase_next;
    e2c_item_t        item_reg, item_next;

    logic [31:0]      recip;
    logic [63:0]      prod;
    logic [31:0]      quot;
    logic [31:0]      quo_mul;
    logic [31:0]      rem_full;
    logic [5:0]       rem_step;
    logic             last_step;
    logic [21:0]      hours;
    logic             days_high;
    logic             dividing;

    always_comb begin
        case (state_reg)
            F_SEC:   recip = RECIP_60;
            F_MIN:   recip = RECIP_60;
            F_HOUR:  recip = RECIP_24;
            default: recip = RECIP_7;
        endcase
    end

    // 32 by 32 multiply, the upper operand halves are zero
    assign prod = {32'd0, dvd_reg} * {32'd0, recip};

    // quotient from the product, and quotient times divisor for the remainder
    always_comb begin
        case (state_reg)
            F_SEC: begin
                quot    = 32'(prod >> RECIP_60_SHIFT);
                quo_mul = quo_reg * 32'(SEC_PER_MIN);
            end
            F_MIN: begin
                quot    = 32'(prod >> RECIP_60_SHIFT);
                quo_mul = quo_reg * 32'(MIN_PER_HOUR);
            end
            F_HOUR: begin
                quot    = 32'(prod >> RECIP_24_SHIFT);
                quo_mul = quo_reg * 32'(HOUR_PER_DAY);
            end
            default: begin
                quot    = 32'(prod >> RECIP_7_SHIFT);
                quo_mul = quo_reg * 32'(DAYS_PER_WEEK);
            end
        endcase
    end

    // each division: quotient registered, then remainder and new dividend
    assign rem_full  = dvd_reg - quo_mul;
    assign rem_step  = rem_full[5:0];
    assign last_step = phase_reg;
    assign dividing  = (state_reg == F_SEC) || (state_reg == F_MIN) ||
                       (state_reg == F_HOUR) || (state_reg == F_WDAY);

    // whole hours plus sign-extended zone offset
    assign hours     = {1'b0, dvd_reg[20:0]} + {{17{zone_offset_hours[4]}}, zone_offset_hours};
    assign days_high = dvd_reg[15:0] >= DAYS_1970_TO_2099;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) state_next = F_SEC;
            end
            F_SEC: begin
                if (last_step) state_next = F_MIN;
            end
            F_MIN: begin
                if (last_step) state_next = F_ZONE;
            end
            F_ZONE: begin
                state_next = hours[21] ? F_PUSH : F_HOUR;
            end
            F_HOUR: begin
                if (last_step) state_next = F_CHK;
            end
            F_CHK: begin
                state_next = days_high ? F_PUSH : F_WDAY;
            end
            F_WDAY: begin
                if (last_step) state_next = F_PUSH;
            end
            F_PUSH: begin
                if (out_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        phase_next = phase_reg;
        item_next  = item_reg;
        if (dividing) begin
            phase_next = !phase_reg;
            if (phase_reg) begin
                dvd_next = quo_reg;
            end else begin
                quo_next = quot;
            end
        end
        case (state_reg)
            F_IDLE: begin
                dvd_next   = in_seconds;
                phase_next = 1'b0;
                item_next  = '0;
            end
            F_SEC: begin
                if (last_step) item_next.second = rem_step;
            end
            F_MIN: begin
                if (last_step) item_next.minute = rem_step;
            end
            F_ZONE: begin
                if (hours[21]) begin
                    item_next.oor = 1'b1;
                end else begin
                    dvd_next = {11'd0, hours[20:0]};
                end
            end
            F_HOUR: begin
                if (last_step) item_next.hour = rem_step[4:0];
            end
            F_CHK: begin
                item_next.days = dvd_reg[15:0];
                if (days_high) begin
                    item_next.oor = 1'b1;
                end else begin
                    // 1-based day number for the weekday
                    dvd_next = {16'd0, dvd_reg[15:0] + 16'd1};
                end
            end
            F_WDAY: begin
                if (last_step) item_next.wday = rem_step[2:0];
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        in_ready  = state_reg == F_IDLE;
        out_valid = state_reg == F_PUSH;
        out_item  = item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        item_reg <= item_next;
    end

endmodule

[rtl/e2c_fifo.sv]
// short register queue of classified items between front and back end
// uses e2c_pkg for the item type and default depth
module e2c_fifo
    import e2c_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  e2c_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output e2c_item_t out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    e2c_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

[rtl/e2c_back.sv]
// back end: walks years and months one per cycle, forms the weekday and
// holds the result in an output register; uses e2c_pkg
module e2c_back
    import e2c_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  e2c_item_t   in_item,
    input  logic [2:0]  weekday_base,
    output logic        out_valid,
    input  logic        out_ready,
    output e2c_result_t out_result
);

    e2c_back_state_t state_reg, state_next;
    e2c_item_t       item_reg, item_next;
    logic [15:0]     rem_reg, rem_next;
    logic [7:0]      yoff_reg, yoff_next;
    logic [3:0]      mon_reg, mon_next;
    e2c_result_t     res_reg, res_next;
    logic            res_valid_reg, res_valid_next;

    logic            leap;
    logic [8:0]      ylen;
    logic            year_fits;
    logic [4:0]      mlen;
    logic            month_done;
    logic            res_free;
    logic [3:0]      wsum;
    logic [3:0]      wday_fixed;
    e2c_result_t     res_built;

    assign leap       = yoff_reg[1:0] == LEAP_PHASE;
    assign ylen       = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
    assign year_fits  = rem_reg < {7'd0, ylen};
    assign mlen       = month_len(mon_reg, leap);
    assign month_done = (rem_reg < {11'd0, mlen}) || (mon_reg == MONTH_DEC);
    assign res_free   = !res_valid_reg || out_ready;

    // weekday sum stays below twice the week length plus one
    assign wsum = {1'b0, item_reg.wday} + {1'b0, weekday_base};
    always_comb begin
        if (wsum >= 4'(2 * DAYS_PER_WEEK)) begin
            wday_fixed = wsum - 4'(2 * DAYS_PER_WEEK);
        end else if (wsum >= 4'(DAYS_PER_WEEK)) begin
            wday_fixed = wsum - 4'(DAYS_PER_WEEK);
        end else begin
            wday_fixed = wsum;
        end
    end

    always_comb begin
        res_built = '0;
        if (item_reg.oor) begin
            res_built.oor = 1'b1;
        end else begin
            res_built.year         = BASE_YEAR + {4'd0, yoff_reg};
            res_built.month        = mon_reg + 4'd1;
            res_built.day_of_month = rem_reg[4:0] + 5'd1;
            res_built.hour         = item_reg.hour;
            res_built.minute       = item_reg.minute;
            res_built.second       = item_reg.second;
            res_built.weekday      = wday_fixed[2:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (in_valid) state_next = in_item.oor ? B_OUT : B_YEAR;
            end
            B_YEAR: begin
                if (year_fits) state_next = B_MONTH;
            end
            B_MONTH: begin
                if (month_done) state_next = B_OUT;
            end
            B_OUT: begin
                if (res_free) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        item_next      = item_reg;
        rem_next       = rem_reg;
        yoff_next      = yoff_reg;
        mon_next       = mon_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (out_ready) res_valid_next = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (in_valid) begin
                    item_next = in_item;
                    rem_next  = in_item.days;
                    yoff_next = 8'd0;
                    mon_next  = MONTH_JAN;
                end
            end
            B_YEAR: begin
                if (!year_fits) begin
                    rem_next  = rem_reg - {7'd0, ylen};
                    yoff_next = yoff_reg + 8'd1;
                end
            end
            B_MONTH: begin
                if (!month_done) begin
                    rem_next = rem_reg - {11'd0, mlen};
                    mon_next = mon_reg + 4'd1;
                end
            end
            B_OUT: begin
                if (res_free) begin
                    res_next       = res_built;
                    res_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        in_ready   = state_reg == B_IDLE;
        out_valid  = res_valid_reg;
        out_result = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        rem_reg  <= rem_next;
        yoff_reg <= yoff_next;
        mon_reg  <= mon_next;
        res_reg  <= res_next;
    end

endmodule

[rtl/epoch_seconds_to_calendar.sv]
// top level of the epoch seconds to calendar converter
// depends on e2c_pkg, e2c_front, e2c_fifo and e2c_back
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year,
// month, day of month, hour, minute, second and weekday. The signed zone
// offset register is added to the whole-hour count before days are split
// off; leap years follow the every-fourth-year rule (1970..2099). If the
// adjusted time falls before 1970 or after 2099, m_tuser is 1 and all date
// and time fields are zero. The front end works through four divisions by
// constants (60, 60, 24 and 7), each a reciprocal multiply step and a
// remainder step, plus zone, range and hand-off steps, and cuts the steps
// short for out-of-range items; it takes a new item only after handing the
// last one on. The back end loads an item, walks the years from 1970 and
// then the months, one per cycle, and ends in an output step. A two-entry
// queue parts the two, so the front end can go on with further items while
// the back end walks. The result sits in an output register, so the back
// end starts the next item while a result waits. Configuration writes are
// taken in any cycle and must only be made while the block is idle.
module epoch_seconds_to_calendar
    import e2c_pkg::*;
#(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [11:0] year, [15:12] month, [20:16] day_of_month,
                                   // [25:21] hour, [31:26] minute, [37:32] second,
                                   // [40:38] weekday, [47:41] zero
    output logic        m_tuser,   // [0] out_of_range
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_wdata
);

    // configuration registers
    logic [4:0] zone_reg, zone_next;
    logic [2:0] base_reg, base_next;

    e2c_item_t   front_item;
    logic        front_valid;
    logic        front_ready;
    e2c_item_t   back_item;
    logic        back_valid;
    logic        back_ready;
    e2c_result_t result;

    // register writes; an index beyond the list is dropped
    always_comb begin
        zone_next = zone_reg;
        base_next = base_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ZONE_OFFSET:  zone_next = cfg_wdata;
                REG_WEEKDAY_BASE: base_next = cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg <= 5'd0;
            base_reg <= 3'd0;
        end else begin
            zone_reg <= zone_next;
            base_reg <= base_next;
        end
    end

    // front: time of day split and zone/range classification
    e2c_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .in_seconds        (s_tdata),
        .zone_offset_hours (zone_reg),
        .out_valid         (front_valid),
        .out_ready         (front_ready),
        .out_item          (front_item)
    );

    // queue between the two ends
    e2c_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    // back: year and month walk, weekday, output register
    e2c_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (back_valid),
        .in_ready     (back_ready),
        .in_item      (back_item),
        .weekday_base (base_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (result)
    );

    // pack the result fields, lowest first
    assign m_tdata = {7'd0, result.weekday, result.second, result.minute, result.hour,
                      result.day_of_month, result.month, result.year};
    assign m_tuser = result.oor;

endmodule

[tb/calendar_checker.sv]
// checker for the epoch seconds to calendar block: predicts each result from the
// input transfers and register writes it sees, and compares the result transfers
// depends on e2c_pkg for the register indexes, the result layout and the day limit
module calendar_checker
    import e2c_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    output int          fail_count,
    output int          outstanding
);

    logic signed [4:0] zone_hours;
    logic [2:0]        day_base;
    e2c_result_t       expected_dates[$];

    function automatic e2c_result_t predict_calendar(input logic [31:0] secs,
                                                     input logic signed [4:0] zone,
                                                     input logic [2:0] base);
        e2c_result_t r;
        longint      hours;
        longint      days0;
        longint      rem;
        int          yr;
        int          mon;
        int          ylen;
        int          mlen;
        int          month_days [12];
        month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        r = '0;
        hours = longint'(secs / 32'd3600) + longint'(zone);
        if (hours < 0) begin
            r.oor = 1'b1;
            return r;
        end
        days0 = hours / 24;
        if (days0 >= longint'(DAYS_1970_TO_2099)) begin
            r.oor = 1'b1;
            return r;
        end
        r.hour    = 5'(hours % 24);
        r.minute  = 6'((secs / 32'd60) % 32'd60);
        r.second  = 6'(secs % 32'd60);
        r.weekday = 3'((((days0 + 1) % 7) + longint'(base)) % 7);
        // walk whole years, then whole months, leaving the day within the month
        rem = days0;
        yr  = int'(BASE_YEAR);
        while (1) begin
            ylen = (yr % 4 == 0) ? 366 : 365;
            if (rem < ylen)
                break;
            rem -= ylen;
            yr++;
        end
        mon = 0;
        while (1) begin
            mlen = (mon == 1 && yr % 4 == 0) ? 29 : month_days[mon];
            if (rem < mlen || mon == 11)
                break;
            rem -= mlen;
            mon++;
        end
        r.year         = 12'(yr);
        r.month        = 4'(mon + 1);
        r.day_of_month = 5'(rem + 1);
        r.oor          = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        e2c_result_t want;
        if (!aresetn) begin
            zone_hours = '0;
            day_base   = '0;
            fail_count = 0;
            expected_dates.delete();
        end else begin
            // predict with the settings in force before any write at this edge
            if (s_tvalid && s_tready)
                expected_dates.push_back(predict_calendar(s_tdata, zone_hours, day_base));
            if (m_tvalid && m_tready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("unexpected result transfer, tdata", m_tdata, 0);
                end else begin
                    want = expected_dates.pop_front();
                    if (m_tdata[11:0] != want.year)
                        report_mismatch("year", m_tdata[11:0], want.year);
                    if (m_tdata[15:12] != want.month)
                        report_mismatch("month", m_tdata[15:12], want.month);
                    if (m_tdata[20:16] != want.day_of_month)
                        report_mismatch("day_of_month", m_tdata[20:16], want.day_of_month);
                    if (m_tdata[25:21] != want.hour)
                        report_mismatch("hour", m_tdata[25:21], want.hour);
                    if (m_tdata[31:26] != want.minute)
                        report_mismatch("minute", m_tdata[31:26], want.minute);
                    if (m_tdata[37:32] != want.second)
                        report_mismatch("second", m_tdata[37:32], want.second);
                    if (m_tdata[40:38] != want.weekday)
                        report_mismatch("weekday", m_tdata[40:38], want.weekday);
                    if (m_tdata[47:41] != 7'd0)
                        report_mismatch("padding", m_tdata[47:41], 0);
                    if (m_tuser != want.oor)
                        report_mismatch("out_of_range", m_tuser, want.oor);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ZONE_OFFSET: begin
                        zone_hours = cfg_wdata;
                    end
                    REG_WEEKDAY_BASE: begin
                        day_base = cfg_wdata[2:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        outstanding = expected_dates.size();
    end

endmodule

[tb/testbench.sv]
// top of the epoch seconds to calendar testbench: clock, reset, stimulus and verdict
// depends on e2c_pkg, epoch_seconds_to_calendar and calendar_checker
module testbench
    import e2c_pkg::*;
();

    // indexes past the register list, writes there must change nothing
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 235;
    // settle time after the last result before a register write
    localparam int IDLE_SETTLE     = 10;
    localparam int END_SETTLE      = 300;
    localparam int CYCLE_LIMIT     = 3000000;

    // epoch seconds of a few calendar landmarks
    localparam logic [31:0] END_OF_1970     = 32'd31535999;
    localparam logic [31:0] END_OF_JAN_1970 = 32'd2678399;
    localparam logic [31:0] LEAP_DAY_1972   = 32'd68169600;
    localparam logic [31:0] END_LEAP_2000   = 32'd951868799;
    localparam logic [31:0] LAST_SEC_2099   = 32'd4102444799;
    localparam logic [31:0] FIRST_SEC_2100  = 32'd4102444800;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] epoch_seconds
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // [11:0] year, [15:12] month, [20:16] day_of_month,
                                 // [25:21] hour, [31:26] minute, [37:32] second,
                                 // [40:38] weekday, [47:41] zero
    logic        m_tuser;        // [0] out_of_range
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;

    // per-phase switches, off gives stretches without idle cycles
    bit s_idle_on = 1'b1;
    bit m_idle_on = 1'b1;

    epoch_seconds_to_calendar u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    calendar_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: a random stall before each transfer, then ready held until it happens
    initial begin : result_sink
        int stall;
        forever begin
            stall = m_idle_on ? $urandom_range(0, 5) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one input transfer; valid stays high into the next call when it draws no gap
    task automatic send_epoch(input logic [31:0] secs);
        int gap;
        gap = s_idle_on ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait until every pending result has come out
    task automatic wait_for_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (IDLE_SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [4:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // zone is 5-bit two's complement; the upper bits of the base write are junk
    task automatic apply_setting(input logic [4:0] zone, input logic [2:0] base);
        write_reg(REG_ZONE_OFFSET, zone);
        write_reg(REG_WEEKDAY_BASE, {2'($urandom_range(0, 3)), base});
    endtask

    // mostly uniform seconds, the rest aimed at day edges, the first days (negative
    // zones underflow there), the end of 2099 and the top of the 32-bit range
    function automatic logic [31:0] pick_epoch();
        logic [31:0] day;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                return $urandom();
            end
            4: begin
                day = $urandom_range(0, 47481);
                return day * 32'd86400 + ($urandom_range(0, 1) ?
                       32'($urandom_range(0, 2)) : 32'd86397 + $urandom_range(0, 2));
            end
            5: begin
                return $urandom_range(0, 172799);
            end
            6: begin
                return 32'd4102272000 + $urandom_range(0, 345599);
            end
            7: begin
                return $urandom_range(32'hFFFF0000, 32'hFFFFFFFF);
            end
            default: begin
                return $urandom_range(0, LAST_SEC_2099);
            end
        endcase
    endfunction

    initial begin : stimulus
        logic [4:0] zone;
        logic [2:0] base;
        int p;
        int i;

        // synchronous reset, released on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, field extremes and calendar edges
        apply_setting(5'sd0, 3'd0);
        send_epoch(32'd0);
        send_epoch(32'd59);
        send_epoch(32'd60);
        send_epoch(32'd3599);
        send_epoch(32'd86399);
        send_epoch(32'd86400);
        send_epoch(END_OF_JAN_1970);
        send_epoch(END_OF_1970);
        send_epoch(LEAP_DAY_1972);
        send_epoch(END_LEAP_2000);
        send_epoch(LAST_SEC_2099);
        send_epoch(FIRST_SEC_2100);
        send_epoch(32'hFFFFFFFF);

        // most negative supported zone: the first half day falls before 1970
        wait_for_idle();
        apply_setting(-5'sd12, 3'd6);
        send_epoch(32'd0);
        send_epoch(32'd43199);
        send_epoch(32'd43200);
        send_epoch(LAST_SEC_2099);

        // most positive supported zone: the last local second of 2099 and past it
        wait_for_idle();
        apply_setting(5'sd14, 3'd3);
        send_epoch(LAST_SEC_2099 - 32'd50400);
        send_epoch(LAST_SEC_2099 - 32'd50399);
        send_epoch(32'd0);

        // random phases, register extremes first, then random settings
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin zone = 5'sd0;   base = 3'd0; end
                1: begin zone = -5'sd12; base = 3'd6; end
                2: begin zone = 5'sd14;  base = 3'd1; end
                3: begin zone = -5'sd16; base = 3'd7; end
                4: begin zone = 5'sd15;  base = 3'd5; end
                default: begin
                    zone = 5'($urandom_range(0, 31));
                    base = 3'($urandom_range(0, 7));
                end
            endcase
            wait_for_idle();
            apply_setting(zone, base);
            // stray writes past the register list
            if (p == 3 || p == 6) begin
                write_reg(REG_SPARE_A, 5'($urandom_range(0, 31)));
                write_reg(REG_SPARE_B, 5'h1F);
            end
            s_idle_on = ($urandom_range(0, 3) != 0);
            m_idle_on = ($urandom_range(0, 3) != 0);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                // hold off mid-phase until the pipeline has drained
                if (p == 1 && i == ITEMS_PER_PHASE / 2)
                    wait_for_idle();
                send_epoch(pick_epoch());
            end
        end

        wait_for_idle();
        repeat (END_SETTLE) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/e2c_pkg.sv
rtl/e2c_front.sv
rtl/e2c_fifo.sv
rtl/e2c_back.sv
rtl/epoch_seconds_to_calendar.sv
tb/calendar_checker.sv
tb/testbench.sv
